/* rtl/ufp_pkg.sv */
package ufp_pkg;

   // Field widths fixed by the transaction formats.
   localparam int BYTE_W    = 8;
   localparam int OP_W      = 2;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 3;
   localparam int SIZE_W    = 6;
   localparam int INDEX_W   = 5;
   localparam int QCOUNT_W  = 3;
   localparam int IDLE_W    = 17;
   localparam int TIMEOUT_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;

   // Largest number of payload results one pop may produce.
   localparam int POP_LIMIT = 32;

   // Operation codes of a request.
   localparam logic [OP_W-1:0] OP_RX_BYTE = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
   localparam logic [OP_W-1:0] OP_POP     = 2'd2;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

   // Byte status codes.
   localparam logic [STATUS_W-1:0] STAT_CONSUMED   = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD_START  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_SIZE_BAD   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_QUEUED     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_QUEUE_FULL = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_START_BYTE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT     = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [BYTE_W-1:0] rx_byte;
   } ufp_req_type;

   typedef struct packed {
      logic [KIND_W-1:0]   result_kind;
      logic [STATUS_W-1:0] byte_status;
      logic [BYTE_W-1:0]   msg_type;
      logic [SIZE_W-1:0]   msg_size;
      logic [BYTE_W-1:0]   payload_byte;
      logic [INDEX_W-1:0]  payload_index;
      logic                last;
      logic [QCOUNT_W-1:0] queue_count;
   } ufp_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                byte_accept;
      logic                tick;
      logic                store_type;
      logic                store_size;
      logic                clear_count;
      logic                store_data;
      logic                commit;
      logic                load_status;
      logic [STATUS_W-1:0] status;
      logic                pop_start;
      logic                pop_empty;
      logic                pop_emit;
   } ufp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic timed_out;
      logic is_start;
      logic size_bad;
      logic frame_done;
      logic queue_full;
      logic queue_empty;
      logic pop_last;
   } ufp_sts_type;

endpackage

/* rtl/uart_frame_parser_with_queue.sv */
// Length-prefixed frame deframer with a message queue. Each received byte
// request returns one status result in the cycle after it is accepted; tick
// requests and the unused operation code return nothing and are taken even
// while a result waits at the output. A pop of an empty queue returns one
// result; a pop of a held message occupies the block until its last byte
// leaves: ST_HDR reads the header and the first payload byte from the queue
// memories, then one payload byte leaves per cycle, paced by the registered
// read port of the payload memory and by rsp_stall. Payload bytes are written
// straight into the free queue slot as they arrive, so committing a frame
// takes no copy. The queue memories need no clearing after reset.
module uart_frame_parser_with_queue #(
   parameter int MAX_PAYLOAD = 32,
   parameter int QUEUE_SLOTS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ufp_pkg::ufp_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ufp_pkg::ufp_rsp_type            rsp_data,
   input  logic                            csr_write,
   input  logic [ufp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ufp_pkg::CSR_W-1:0]       csr_data
);
   import ufp_pkg::*;

   ufp_cmd_type cmd;
   ufp_sts_type sts;

   // Parser and pop sequencer.
   ufp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Registers, queue memories and output register.
   ufp_dp #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .QUEUE_SLOTS (QUEUE_SLOTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_rx_byte (req_data.rx_byte),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

/* rtl/ufp_ctrl.sv */
module ufp_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [ufp_pkg::OP_W-1:0]     req_op,
   output logic                         req_stall,
   input  ufp_pkg::ufp_sts_type         sts,
   output ufp_pkg::ufp_cmd_type         cmd
);
   import ufp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HDR,
      ST_DATA
   } state_type;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_TYPE,
      PH_SIZE,
      PH_DATA
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in, phase_eff;
   logic      needs_out;
   logic      accept;

   // Handshake, frame parser and pop sequencer decisions.
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      phase_in  = phase_ff;
      // A byte that arrives after the idle limit is judged as a start byte.
      phase_eff = sts.timed_out ? PH_HUNT : phase_ff;
      needs_out = (req_op == OP_RX_BYTE) || (req_op == OP_POP);
      req_stall = (state_ff != ST_IDLE) || (needs_out && !sts.out_free);
      accept    = req_valid && !req_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_RX_BYTE: begin
                     cmd.byte_accept = 1'b1;
                     cmd.load_status = 1'b1;
                     cmd.status      = STAT_CONSUMED;
                     unique case (phase_eff)
                        PH_HUNT: begin
                           if (sts.is_start) begin
                              phase_in = PH_TYPE;
                           end else begin
                              phase_in   = PH_HUNT;
                              cmd.status = STAT_BAD_START;
                           end
                        end
                        PH_TYPE: begin
                           cmd.store_type = 1'b1;
                           phase_in       = PH_SIZE;
                        end
                        PH_SIZE: begin
                           cmd.store_size = 1'b1;
                           if (sts.size_bad) begin
                              cmd.status = STAT_SIZE_BAD;
                              phase_in   = PH_HUNT;
                           end else begin
                              cmd.clear_count = 1'b1;
                              phase_in        = PH_DATA;
                           end
                        end
                        PH_DATA: begin
                           cmd.store_data = 1'b1;
                           if (sts.frame_done) begin
                              phase_in = PH_HUNT;
                              if (sts.queue_full) begin
                                 cmd.status = STAT_QUEUE_FULL;
                              end else begin
                                 cmd.commit = 1'b1;
                                 cmd.status = STAT_QUEUED;
                              end
                           end
                        end
                     endcase
                  end
                  OP_TICK: begin
                     cmd.tick = 1'b1;
                  end
                  OP_POP: begin
                     if (sts.queue_empty) begin
                        cmd.pop_empty = 1'b1;
                     end else begin
                        cmd.pop_start = 1'b1;
                        state_in      = ST_HDR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // Header and first payload byte are read from memory.
         ST_HDR: begin
            state_in = ST_DATA;
         end
         // One payload byte leaves whenever the output register is free.
         ST_DATA: begin
            if (sts.out_free) begin
               cmd.pop_emit = 1'b1;
               if (sts.pop_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer and parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_HUNT;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

/* rtl/ufp_dp.sv */
module ufp_dp #(
   parameter int MAX_PAYLOAD = 32,
   parameter int QUEUE_SLOTS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ufp_pkg::BYTE_W-1:0]      req_rx_byte,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output ufp_pkg::ufp_rsp_type            rsp_data,
   input  logic                            csr_write,
   input  logic [ufp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ufp_pkg::CSR_W-1:0]       csr_data,
   input  ufp_pkg::ufp_cmd_type            cmd,
   output ufp_pkg::ufp_sts_type            sts
);
   import ufp_pkg::*;

   localparam int IDXW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int SLOTW     = $clog2(QUEUE_SLOTS);
   localparam int QCW       = (SLOTW + 1 > QCOUNT_W) ? SLOTW + 1 : QCOUNT_W;
   localparam int ADDRW     = SLOTW + IDXW;
   localparam int PAY_DEPTH = QUEUE_SLOTS * (2 ** IDXW);
   localparam int HDR_W     = BYTE_W + SIZE_W;

   function automatic logic [SLOTW-1:0] next_slot(input logic [SLOTW-1:0] s);
      next_slot = (s == SLOTW'(QUEUE_SLOTS - 1)) ? '0 : s + SLOTW'(1);
   endfunction

   function automatic logic [QCW-1:0] held_count(input logic [SLOTW-1:0] w,
                                                  input logic [SLOTW-1:0] r);
      logic [QCW-1:0] diff;
      diff = QCW'(w) - QCW'(r);
      held_count = (w >= r) ? diff : diff + QCW'(QUEUE_SLOTS);
   endfunction

   // Configuration registers.
   logic [BYTE_W-1:0]    start_byte_ff;
   logic [SIZE_W-1:0]    max_payload_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;

   // Frame assembly and queue control.
   logic [BYTE_W-1:0]    frame_type_ff;
   logic [SIZE_W-1:0]    frame_size_ff;
   logic [SIZE_W-1:0]    byte_count_ff, byte_count_in;
   logic [IDLE_W-1:0]    idle_ff, idle_in;
   logic [SLOTW-1:0]     write_slot_ff, write_slot_in;
   logic [SLOTW-1:0]     read_slot_ff, read_slot_in;
   logic [SLOTW-1:0]     write_next;

   // Pop streaming.
   logic [SLOTW-1:0]     pop_slot_ff;
   logic [INDEX_W-1:0]   pop_idx_ff, pop_idx_in;
   logic [HDR_W-1:0]     hdr_q_ff;
   logic [BYTE_W-1:0]    pd_q_ff;
   logic [SIZE_W:0]      hdr_size_w, clamp_a, clamp_b;
   logic [SIZE_W-1:0]    pop_size;
   logic [SIZE_W-1:0]    pop_idx_w, pop_idx_next;
   logic [ADDRW-1:0]     wr_addr, rd_addr;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   ufp_rsp_type          rsp_data_ff, rsp_data_in;
   logic                 load_out;
   logic [QCW-1:0]       held_after, held_now;
   logic [BYTE_W-1:0]    limit_w;

   logic [BYTE_W-1:0]    hdr_mem [QUEUE_SLOTS];
   logic [BYTE_W-1:0]    pay_mem [PAY_DEPTH];
   logic [SIZE_W-1:0]    hsize_mem [QUEUE_SLOTS];

   // Status toward the controller.
   always_comb begin
      write_next      = next_slot(write_slot_ff);
      limit_w = ({2'b00, max_payload_ff} < BYTE_W'(MAX_PAYLOAD)) ?
                {2'b00, max_payload_ff} : BYTE_W'(MAX_PAYLOAD);
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
      sts.timed_out   = idle_ff > {1'b0, timeout_ff};
      sts.is_start    = req_rx_byte == start_byte_ff;
      sts.size_bad    = (req_rx_byte == '0) || (req_rx_byte > limit_w);
      sts.frame_done  = ({1'b0, byte_count_ff} + (SIZE_W + 1)'(1)) >= {1'b0, frame_size_ff};
      sts.queue_full  = write_next == read_slot_ff;
      sts.queue_empty = write_slot_ff == read_slot_ff;
      // Stored sizes are clamped to the buffer and to the pop result limit.
      hdr_size_w      = {1'b0, hdr_q_ff[SIZE_W-1:0]};
      clamp_a = (hdr_size_w > (SIZE_W + 1)'(MAX_PAYLOAD)) ?
                (SIZE_W + 1)'(MAX_PAYLOAD) : hdr_size_w;
      clamp_b = (clamp_a > (SIZE_W + 1)'(POP_LIMIT)) ? (SIZE_W + 1)'(POP_LIMIT) : clamp_a;
      pop_size        = clamp_b[SIZE_W-1:0];
      pop_idx_w       = {1'b0, pop_idx_ff};
      pop_idx_next    = pop_idx_w + SIZE_W'(1);
      sts.pop_last    = pop_idx_next == pop_size;
   end

   // Next values of the queue pointers, idle counter and pop index.
   always_comb begin
      write_slot_in = cmd.commit ? write_next : write_slot_ff;
      read_slot_in  = cmd.pop_start ? next_slot(read_slot_ff) : read_slot_ff;
      if (cmd.byte_accept) begin
         idle_in = '0;
      end else if (cmd.tick && (idle_ff != '1)) begin
         idle_in = idle_ff + IDLE_W'(1);
      end else begin
         idle_in = idle_ff;
      end
      if (cmd.clear_count) begin
         byte_count_in = '0;
      end else if (cmd.store_data) begin
         byte_count_in = byte_count_ff + SIZE_W'(1);
      end else begin
         byte_count_in = byte_count_ff;
      end
      if (cmd.pop_start) begin
         pop_idx_in = '0;
      end else if (cmd.pop_emit) begin
         pop_idx_in = pop_idx_ff + INDEX_W'(1);
      end else begin
         pop_idx_in = pop_idx_ff;
      end
      wr_addr = {write_slot_ff, byte_count_ff[IDXW-1:0]};
      // The read address moves ahead as soon as a byte leaves.
      rd_addr = cmd.pop_emit ? {pop_slot_ff, pop_idx_next[IDXW-1:0]}
                             : {pop_slot_ff, pop_idx_w[IDXW-1:0]};
      held_after = held_count(write_slot_in, read_slot_in);
      held_now   = held_count(write_slot_ff, read_slot_ff);
   end

   // Result assembly and output register control.
   always_comb begin
      load_out    = cmd.load_status || cmd.pop_empty || cmd.pop_emit;
      rsp_data_in = '0;
      rsp_data_in.last        = 1'b1;
      rsp_data_in.queue_count = held_after[QCOUNT_W-1:0];
      if (cmd.load_status) begin
         rsp_data_in.result_kind = KIND_STATUS;
         rsp_data_in.byte_status = cmd.status;
      end else if (cmd.pop_emit) begin
         rsp_data_in.result_kind   = KIND_PAYLOAD;
         rsp_data_in.msg_type      = hdr_q_ff[HDR_W-1:SIZE_W];
         rsp_data_in.msg_size      = pop_size;
         rsp_data_in.payload_byte  = pd_q_ff;
         rsp_data_in.payload_index = pop_idx_ff;
         rsp_data_in.last          = sts.pop_last;
      end else begin
         rsp_data_in.result_kind = KIND_EMPTY;
      end
      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= '0;
         max_payload_ff <= SIZE_W'(32);
         timeout_ff     <= TIMEOUT_W'(1000);
         idle_ff        <= '0;
         write_slot_ff  <= '0;
         read_slot_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_START_BYTE:  start_byte_ff  <= csr_data[BYTE_W-1:0];
               REG_MAX_PAYLOAD: max_payload_ff <= csr_data[SIZE_W-1:0];
               REG_TIMEOUT:     timeout_ff     <= csr_data[TIMEOUT_W-1:0];
               default: begin
               end
            endcase
         end
         idle_ff       <= idle_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.store_type) begin
         frame_type_ff <= req_rx_byte;
      end
      if (cmd.store_size) begin
         frame_size_ff <= req_rx_byte[SIZE_W-1:0];
      end
      byte_count_ff <= byte_count_in;
      if (cmd.pop_start) begin
         pop_slot_ff <= read_slot_ff;
      end
      pop_idx_ff <= pop_idx_in;
      if (load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Queue memories. Payload bytes land straight in the free slot; the
   // header is written when the frame is committed.
   always_ff @(posedge clock) begin
      if (cmd.store_data) begin
         pay_mem[wr_addr] <= req_rx_byte;
      end
      if (cmd.commit) begin
         hdr_mem[write_slot_ff]   <= frame_type_ff;
         hsize_mem[write_slot_ff] <= frame_size_ff;
      end
      pd_q_ff  <= pay_mem[rd_addr];
      hdr_q_ff <= {hdr_mem[pop_slot_ff], hsize_mem[pop_slot_ff]};
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result is only loaded when the output register can take it.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> sts.out_free)
      else $error("result loaded into a busy output register");

   // A frame is never committed into a full queue.
   a_commit_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !sts.queue_full)
      else $error("frame committed while the queue is full");

   // Streamed payload indexes stay within the message.
   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_emit |-> ({1'b0, pop_idx_ff} < pop_size))
      else $error("payload index beyond message size");

   // One slot always stays unused.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      held_now <= QCW'(QUEUE_SLOTS - 1))
      else $error("queue holds more messages than it has usable slots");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import ufp_pkg::*;

   localparam int SLOTS         = 8;
   localparam int PAYLOAD_MAX   = 32;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int IDLE_PERCENT  = 32;
   localparam int PHASE_ITEMS   = 6;
   localparam logic [IDLE_W-1:0]    IDLE_CEILING = '1;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED   = 2'd3;
   localparam logic [OP_W-1:0]      OP_UNUSED    = 2'd3;

   typedef enum logic [1:0] {HUNT, GET_TYPE, GET_SIZE, GET_DATA} parse_phase_type;

   // Block ports.
   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   ufp_req_type          req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   ufp_rsp_type          rsp_data;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data  = '0;

   // Predicted deframer state and its copy of the registers.
   logic [BYTE_W-1:0]    cfg_start_byte;
   logic [SIZE_W-1:0]    cfg_max_payload;
   logic [TIMEOUT_W-1:0] cfg_timeout;
   parse_phase_type      phase;
   logic [BYTE_W-1:0]    frame_type;
   logic [BYTE_W-1:0]    frame_size;
   logic [SIZE_W-1:0]    byte_count;
   logic [BYTE_W-1:0]    assembly [PAYLOAD_MAX];
   logic [IDLE_W-1:0]    idle_ticks;
   logic [BYTE_W-1:0]    slot_type [SLOTS];
   logic [SIZE_W-1:0]    slot_size [SLOTS];
   logic [BYTE_W-1:0]    slot_bytes [SLOTS][PAYLOAD_MAX];
   logic [2:0]           write_slot;
   logic [2:0]           read_slot;
   ufp_rsp_type          due_results [$];
   ufp_rsp_type          want_result;

   // Run control and bookkeeping.
   bit traffic_gaps    = 1'b1;
   int hold_cycles     = 0;
   int cycle_count     = 0;
   int requests_sent   = 0;
   int results_checked = 0;
   int csr_writes      = 0;
   int mismatches      = 0;

   uart_frame_parser_with_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Payload length limit in force under the current register setting.
   function automatic int frame_limit();
      return (cfg_max_payload < PAYLOAD_MAX) ? int'(cfg_max_payload) : PAYLOAD_MAX;
   endfunction

   // Runs one received byte through the frame parser and returns its status.
   function automatic logic [STATUS_W-1:0] parse_rx_byte(logic [BYTE_W-1:0] b);
      logic [STATUS_W-1:0] status;
      status = STAT_CONSUMED;
      if (idle_ticks > cfg_timeout)
         phase = HUNT;
      idle_ticks = '0;
      case (phase)
         HUNT: begin
            if (b == cfg_start_byte)
               phase = GET_TYPE;
            else
               status = STAT_BAD_START;
         end
         GET_TYPE: begin
            frame_type = b;
            phase = GET_SIZE;
         end
         GET_SIZE: begin
            frame_size = b;
            if (b == 0 || b > frame_limit()) begin
               status = STAT_SIZE_BAD;
               phase = HUNT;
            end else begin
               byte_count = '0;
               phase = GET_DATA;
            end
         end
         default: begin
            if (byte_count < PAYLOAD_MAX)
               assembly[byte_count[4:0]] = b;
            byte_count = byte_count + 1'b1;
            if (byte_count >= frame_size || byte_count >= PAYLOAD_MAX) begin
               // One slot always stays empty, so a full queue drops the frame.
               if (3'(write_slot + 3'd1) == read_slot) begin
                  status = STAT_QUEUE_FULL;
               end else begin
                  slot_type[write_slot] = frame_type;
                  slot_size[write_slot] = frame_size[SIZE_W-1:0];
                  slot_bytes[write_slot] = assembly;
                  write_slot = write_slot + 3'd1;
                  status = STAT_QUEUED;
               end
               phase = HUNT;
            end
         end
      endcase
      return status;
   endfunction

   // Works out the results of one accepted transaction and queues them.
   function automatic void predict_results(ufp_req_type r);
      ufp_rsp_type res;
      logic [2:0] slot;
      res = '0;
      res.last = 1'b1;
      case (r.operation)
         OP_RX_BYTE: begin
            res.result_kind = KIND_STATUS;
            res.byte_status = parse_rx_byte(r.rx_byte);
            res.queue_count = 3'(write_slot - read_slot);
            due_results.push_back(res);
         end
         OP_TICK: begin
            if (idle_ticks != IDLE_CEILING)
               idle_ticks = idle_ticks + 1'b1;
         end
         OP_POP: begin
            if (read_slot == write_slot) begin
               res.result_kind = KIND_EMPTY;
               due_results.push_back(res);
            end else begin
               slot = read_slot;
               read_slot = read_slot + 3'd1;
               for (int i = 0; i < slot_size[slot]; i++) begin
                  res.result_kind   = KIND_PAYLOAD;
                  res.msg_type      = slot_type[slot];
                  res.msg_size      = slot_size[slot];
                  res.payload_byte  = slot_bytes[slot][i[4:0]];
                  res.payload_index = i[INDEX_W-1:0];
                  res.last          = (i + 1 == slot_size[slot]);
                  res.queue_count   = 3'(write_slot - read_slot);
                  due_results.push_back(res);
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= 30)
         $display("cycle %0d: mismatch: %s", cycle_count, what);
   endtask

   task automatic check_field(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
   endtask

   // Offers one transaction, with random idle cycles ahead of it, and holds
   // it until the block takes it.
   task automatic send_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] value);
      ufp_req_type item;
      item.operation = op;
      item.rx_byte = value;
      @(negedge clock);
      while (traffic_gaps && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_results(item);
      if (op != OP_UNUSED)
         requests_sent++;
   endtask

   task automatic send_ticks(int count);
      repeat (count)
         send_request(OP_TICK, 8'($urandom_range(255)));
   endtask

   // Sometimes lets a few idle ticks pass, never more than max_gap.
   task automatic idle_gap(int max_gap);
      if (max_gap > 0 && $urandom_range(3) == 0)
         send_ticks($urandom_range(max_gap));
   endtask

   // Sends a start byte, type and size, and payload bytes if the size is valid.
   task automatic send_frame(logic [BYTE_W-1:0] ftype, logic [BYTE_W-1:0] fsize,
                             int max_gap);
      send_request(OP_RX_BYTE, cfg_start_byte);
      idle_gap(max_gap);
      send_request(OP_RX_BYTE, ftype);
      idle_gap(max_gap);
      send_request(OP_RX_BYTE, fsize);
      if (fsize != 0 && fsize <= frame_limit()) begin
         for (int i = 0; i < fsize; i++) begin
            idle_gap(max_gap);
            send_request(OP_RX_BYTE, 8'($urandom_range(255)));
         end
      end
   endtask

   // Pops every held message, then once more on the empty queue.
   task automatic empty_queue();
      while (write_slot != read_slot)
         send_request(OP_POP, 8'($urandom_range(255)));
      send_request(OP_POP, 8'($urandom_range(255)));
   endtask

   // Stops offering and waits until every expected result has come back.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_W-1:0] value);
      settle();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      case (index)
         REG_START_BYTE:  cfg_start_byte = value[BYTE_W-1:0];
         REG_MAX_PAYLOAD: cfg_max_payload = value[SIZE_W-1:0];
         REG_TIMEOUT:     cfg_timeout = value[TIMEOUT_W-1:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
      csr_writes++;
   endtask

   // Reset settings: empty pop, stray bytes, the smallest and largest frames,
   // zero and oversize lengths, and the unused operation.
   task automatic test_basic_frames();
      send_request(OP_POP, 8'h00);
      send_request(OP_RX_BYTE, 8'hFF);
      send_request(OP_UNUSED, 8'hFF);
      send_request(OP_TICK, 8'h00);
      send_frame(8'hFF, 8'd1, 0);
      send_frame(8'h00, 8'd0, 0);
      send_frame(8'h80, 8'd33, 0);
      send_frame(8'h5A, 8'hFF, 0);
      send_request(OP_POP, 8'hFF);
      send_request(OP_POP, 8'h00);
      send_frame(8'hC3, 8'd32, 0);
      send_request(OP_POP, 8'h00);
   endtask

   // Each register in turn, the ignored index, and idle time between bytes.
   task automatic test_register_settings();
      write_register(REG_START_BYTE, 16'h00A5);
      send_request(OP_RX_BYTE, 8'h00);
      send_frame(8'h11, 8'd2, 0);
      // A zero length limit rejects every size.
      write_register(REG_MAX_PAYLOAD, 16'd0);
      send_frame(8'h22, 8'd1, 0);
      write_register(REG_UNUSED, 16'hFFFF);
      send_frame(8'h33, 8'd1, 0);
      write_register(REG_MAX_PAYLOAD, 16'd1);
      send_frame(8'h44, 8'd1, 0);
      send_frame(8'h55, 8'd2, 0);
      // With no idle time allowed, one tick sends the parser back to hunting.
      write_register(REG_TIMEOUT, 16'd0);
      send_request(OP_RX_BYTE, 8'hA5);
      send_request(OP_TICK, 8'h00);
      send_request(OP_RX_BYTE, 8'hA5);
      send_request(OP_RX_BYTE, 8'h66);
      send_request(OP_RX_BYTE, 8'h01);
      send_request(OP_RX_BYTE, 8'h99);
      // Every byte restarts the idle count, so gaps at the limit are fine.
      write_register(REG_TIMEOUT, 16'd3);
      send_request(OP_RX_BYTE, 8'hA5);
      send_ticks(3);
      send_request(OP_RX_BYTE, 8'h77);
      send_ticks(3);
      send_request(OP_RX_BYTE, 8'h01);
      send_ticks(3);
      send_request(OP_RX_BYTE, 8'h3C);
      send_request(OP_RX_BYTE, 8'hA5);
      send_ticks(4);
      send_request(OP_RX_BYTE, 8'h00);
      empty_queue();
   endtask

   // Largest timeout: idle runs between the bytes of a frame keep it alive.
   task automatic test_timeout_extremes();
      write_register(REG_TIMEOUT, 16'hFFFF);
      traffic_gaps = 1'b0;
      send_request(OP_RX_BYTE, cfg_start_byte);
      send_ticks(4);
      send_request(OP_RX_BYTE, 8'h66);
      send_ticks(4);
      send_request(OP_RX_BYTE, 8'h01);
      send_ticks(2);
      send_request(OP_RX_BYTE, 8'h5E);
      send_request(OP_POP, 8'h00);
      traffic_gaps = 1'b1;
   endtask

   // Seven frames fill the queue; the eighth is dropped.
   task automatic test_queue_full();
      write_register(REG_MAX_PAYLOAD, 16'd4);
      write_register(REG_TIMEOUT, 16'd1000);
      repeat (SLOTS - 1)
         send_frame(8'($urandom_range(255)), 8'($urandom_range(1, 4)), 0);
      send_frame(8'hEE, 8'd3, 0);
      send_request(OP_POP, 8'h00);
      send_frame(8'h77, 8'd4, 0);
      empty_queue();
   endtask

   // The receiver holds off for a long time while pops and bytes keep coming.
   task automatic test_backpressure();
      write_register(REG_MAX_PAYLOAD, 16'd32);
      send_frame(8'($urandom_range(255)), 8'd16, 0);
      send_frame(8'($urandom_range(255)), 8'd16, 0);
      settle();
      hold_cycles = 300;
      send_request(OP_POP, 8'h00);
      send_request(OP_POP, 8'h00);
      repeat (6)
         send_request(OP_RX_BYTE, 8'($urandom_range(255)));
      settle();
      empty_queue();
   endtask

   // One setting of the registers with mostly well-formed random frames.
   task automatic random_phase(logic [7:0] start, logic [5:0] max_len,
                               logic [15:0] timeout, bit gaps);
      int first;
      int pick;
      int lim;
      int size;
      int max_gap;
      write_register(REG_START_BYTE, CSR_W'(start));
      write_register(REG_MAX_PAYLOAD, CSR_W'(max_len));
      write_register(REG_TIMEOUT, timeout);
      traffic_gaps = gaps;
      first = requests_sent;
      lim = frame_limit();
      max_gap = (cfg_timeout < 3) ? cfg_timeout : 3;
      while (requests_sent - first < PHASE_ITEMS) begin
         pick = $urandom_range(99);
         size = ($urandom_range(7) == 0) ? lim : $urandom_range(1, (lim < 8) ? lim : 8);
         if (pick < 65) begin
            send_frame(8'($urandom_range(255)), 8'(size), max_gap);
         end else if (pick < 75) begin
            send_frame(8'($urandom_range(255)),
                       8'($urandom_range(1) ? 0 : $urandom_range(lim + 1, 255)), 0);
         end else if (pick < 85) begin
            // A frame abandoned partway through.
            send_request(OP_RX_BYTE, cfg_start_byte);
            send_request(OP_RX_BYTE, 8'($urandom_range(255)));
            send_request(OP_RX_BYTE, 8'(size));
            repeat ($urandom_range(size - 1))
               send_request(OP_RX_BYTE, 8'($urandom_range(255)));
            if (cfg_timeout < 100)
               send_ticks(cfg_timeout + 1);
         end else begin
            send_request(OP_RX_BYTE, 8'($urandom_range(255)));
            send_request(OP_UNUSED, 8'($urandom_range(255)));
            send_ticks($urandom_range(2));
         end
         if ($urandom_range(99) < 45)
            send_request(OP_POP, 8'($urandom_range(255)));
      end
      traffic_gaps = 1'b1;
   endtask

   task automatic test_random_traffic();
      random_phase(8'h7E, 6'd8, 16'd20, 1'b1);
      random_phase(8'hFF, 6'd32, 16'd5, 1'b1);
      random_phase(8'h00, 6'd1, 16'd0, 1'b1);
      random_phase(8'h3C, 6'd16, 16'hFFFF, 1'b0);
      random_phase(8'h81, 6'd32, 16'd2, 1'b1);
      empty_queue();
   endtask

   // The receiver stalls at random, or for a whole hold-off when one is asked.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= traffic_gaps && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Each result transaction is checked against the oldest expectation.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            report_mismatch("result with no expectation waiting");
         end else begin
            want_result = due_results.pop_front();
            check_field("result_kind", 8'(rsp_data.result_kind),
                        8'(want_result.result_kind));
            check_field("byte_status", 8'(rsp_data.byte_status),
                        8'(want_result.byte_status));
            check_field("msg_type", rsp_data.msg_type, want_result.msg_type);
            check_field("msg_size", 8'(rsp_data.msg_size), 8'(want_result.msg_size));
            check_field("payload_byte", rsp_data.payload_byte, want_result.payload_byte);
            check_field("payload_index", 8'(rsp_data.payload_index),
                        8'(want_result.payload_index));
            check_field("last", 8'(rsp_data.last), 8'(want_result.last));
            check_field("queue_count", 8'(rsp_data.queue_count),
                        8'(want_result.queue_count));
            results_checked++;
         end
      end
   end

   initial begin
      cfg_start_byte = 8'h00;
      cfg_max_payload = 6'd32;
      cfg_timeout = 16'd1000;
      phase = HUNT;
      frame_type = '0;
      frame_size = '0;
      byte_count = '0;
      idle_ticks = '0;
      write_slot = '0;
      read_slot = '0;
      repeat (8)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_frames();
      test_register_settings();
      test_timeout_extremes();
      test_queue_full();
      test_backpressure();
      test_random_traffic();
      settle();

      $display("run covered %0d requests, %0d results checked, %0d register writes",
               requests_sent, results_checked, csr_writes);
      $display("including a full queue, both timeout extremes and a long output hold-off");
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* filelist.f */
rtl/ufp_pkg.sv
rtl/ufp_ctrl.sv
rtl/ufp_dp.sv
rtl/uart_frame_parser_with_queue.sv
tb/testbench.sv
